### rtl/core/mdra_pkg.sv
// Shared constants, codes and control structs of the dirty-region accumulator.
package mdra_pkg;

  localparam int TILE_SHIFT_DEF = 5;
  localparam int GRID_W_DEF     = 64;
  localparam int GRID_H_DEF     = 64;

  localparam int PIX_W       = 16;
  localparam int PIX_END_W   = 17;
  localparam int TILE_IDX_W  = 12;
  localparam int ORIGIN_W    = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int STATUS_W    = 2;
  localparam int BOX_W       = 6;
  localparam int COORD_W     = 17;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CLIP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SKIP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;

  typedef struct packed {
    logic load;
    logic calc;
    logic init;
    logic step;
    logic rd_tile;
    logic emit_add;
    logic emit_rd;
    logic clear_wr;
  } mdra_cmd_t;

  typedef struct packed {
    logic cmd_rd;
    logic skip;
    logic last;
    logic clear_last;
  } mdra_stat_t;

endpackage

### rtl/core/mdra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mdra_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

### rtl/core/mdra_ctrl.sv
// Sequencer for clearing, add and read commands of the dirty-region accumulator.
module mdra_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output mdra_pkg::mdra_cmd_t cmd,
  input  mdra_pkg::mdra_stat_t stat
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_INIT  = 3'd3;
  localparam logic [2:0] S_RUN   = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_RDOUT = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (stat.cmd_rd) begin
          cmd.rd_tile = 1'b1;
          state_nxt   = S_RDOUT;
        end else begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        if (stat.skip) begin
          cmd.emit_add = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.init  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (stat.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.emit_add = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_RDOUT: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.emit_add | cmd.emit_rd;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### rtl/core/mdra_dp.sv
// Datapath: command registers, grid clipping, tile walk and box read-modify-write.
module mdra_dp #(
  parameter int TILE_SHIFT = mdra_pkg::TILE_SHIFT_DEF,
  parameter int GRID_W     = mdra_pkg::GRID_W_DEF,
  parameter int GRID_H     = mdra_pkg::GRID_H_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mdra_pkg::mdra_cmd_t               cmd,
  output mdra_pkg::mdra_stat_t              stat,
  input  logic                              in_cmd,
  input  logic [mdra_pkg::PIX_W-1:0]        in_rect_left,
  input  logic [mdra_pkg::PIX_W-1:0]        in_rect_top,
  input  logic [mdra_pkg::PIX_END_W-1:0]    in_rect_right,
  input  logic [mdra_pkg::PIX_END_W-1:0]    in_rect_bottom,
  input  logic [mdra_pkg::TILE_IDX_W-1:0]   in_tile_index,
  input  logic                              cfg_valid,
  input  logic [mdra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mdra_pkg::ORIGIN_W-1:0]     cfg_data,
  output logic [mdra_pkg::STATUS_W-1:0]     out_status,
  output logic [mdra_pkg::BOX_W-1:0]        out_box_left,
  output logic [mdra_pkg::BOX_W-1:0]        out_box_top,
  output logic [mdra_pkg::BOX_W-1:0]        out_box_right,
  output logic [mdra_pkg::BOX_W-1:0]        out_box_bottom
);

  localparam int NTILES = GRID_W * GRID_H;
  localparam int AW     = (NTILES > 1) ? $clog2(NTILES) : 1;
  localparam int EW     = TILE_SHIFT + 1;
  localparam int DW     = 4 * EW;
  localparam int CW     = mdra_pkg::COORD_W;
  localparam int PW     = mdra_pkg::PIX_W;
  localparam int QW     = mdra_pkg::PIX_END_W;
  localparam int IW     = mdra_pkg::TILE_IDX_W;
  localparam int BW     = mdra_pkg::BOX_W;
  localparam logic [EW-1:0] TILE_SIZE = EW'(1 << TILE_SHIFT);

  logic [mdra_pkg::ORIGIN_W-1:0] ox_r, oy_r;

  logic          cmd_rd_r;
  logic [PW-1:0] l_r, t_r;
  logic [QW-1:0] r_r, b_r;
  logic [IW-1:0] idx_r;

  logic [CW-1:0] tx1_r, tx2_r, ty1_r, ty2_r;
  logic [CW-1:0] cx1_r, cx2_r, cy1_r, cy2_r;
  logic [EW-1:0] xf1_r, xf2_r, yf1_r, yf2_r;
  logic          skip_r;
  logic [mdra_pkg::STATUS_W-1:0] status_r;

  logic [CW-1:0] tx_r, ty_r;
  logic [AW-1:0] col_r, col0_r, rowbase_r;

  logic          p_valid_r;
  logic [AW-1:0] p_addr_r;
  logic [EW-1:0] p_el_r, p_et_r, p_er_r, p_eb_r;

  logic [AW-1:0] clr_r;

  logic [mdra_pkg::STATUS_W-1:0] out_status_r;
  logic [BW-1:0] out_box_left_r, out_box_top_r, out_box_right_r, out_box_bottom_r;

  logic [QW-1:0] rm1, bm1;
  logic [CW-1:0] tx1, tx2, ty1, ty2, gx1, gy1, gx2, gy2;
  logic [CW-1:0] cx1, cx2, cy1, cy2;
  logic          empty, outside, clipped;
  logic [CW-1:0] dy, rowmul;
  logic [AW-1:0] run_addr, idx_addr, rd_addr, wr_addr;
  logic [IW+AW-1:0] idx_ext;
  logic          idx_ok;
  logic          we;
  logic [DW-1:0] wr_data, rd_data;
  logic [EW-1:0] old_l, old_t, old_r, old_b;
  logic [EW-1:0] new_l, new_t, new_r, new_b;
  logic [EW+BW-1:0] ext_l, ext_t, ext_r, ext_b;
  logic          row_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0;
      oy_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mdra_pkg::CFG_ORIGIN_X: ox_r <= cfg_data;
        mdra_pkg::CFG_ORIGIN_Y: oy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_rd_r <= (in_cmd == mdra_pkg::CMD_READ);
      l_r      <= in_rect_left;
      t_r      <= in_rect_top;
      r_r      <= in_rect_right;
      b_r      <= in_rect_bottom;
      idx_r    <= in_tile_index;
    end
  end

  always_comb begin
    rm1     = r_r - QW'(1);
    bm1     = b_r - QW'(1);
    empty   = (QW'(l_r) >= r_r) || (QW'(t_r) >= b_r);
    tx1     = CW'(l_r >> TILE_SHIFT);
    ty1     = CW'(t_r >> TILE_SHIFT);
    tx2     = CW'(rm1 >> TILE_SHIFT);
    ty2     = CW'(bm1 >> TILE_SHIFT);
    gx1     = CW'(ox_r);
    gy1     = CW'(oy_r);
    gx2     = CW'(ox_r) + CW'(GRID_W - 1);
    gy2     = CW'(oy_r) + CW'(GRID_H - 1);
    cx1     = (tx1 > gx1) ? tx1 : gx1;
    cy1     = (ty1 > gy1) ? ty1 : gy1;
    cx2     = (tx2 < gx2) ? tx2 : gx2;
    cy2     = (ty2 < gy2) ? ty2 : gy2;
    outside = (cx1 > cx2) || (cy1 > cy2);
    clipped = (cx1 != tx1) || (cy1 != ty1) || (cx2 != tx2) || (cy2 != ty2);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      tx1_r  <= tx1;
      tx2_r  <= tx2;
      ty1_r  <= ty1;
      ty2_r  <= ty2;
      cx1_r  <= cx1;
      cx2_r  <= cx2;
      cy1_r  <= cy1;
      cy2_r  <= cy2;
      xf1_r  <= EW'(l_r[TILE_SHIFT-1:0]);
      yf1_r  <= EW'(t_r[TILE_SHIFT-1:0]);
      xf2_r  <= EW'(rm1[TILE_SHIFT-1:0]) + EW'(1);
      yf2_r  <= EW'(bm1[TILE_SHIFT-1:0]) + EW'(1);
      skip_r <= empty || outside;
      if (empty || outside) begin
        status_r <= mdra_pkg::ST_SKIP;
      end else if (clipped) begin
        status_r <= mdra_pkg::ST_CLIP;
      end else begin
        status_r <= mdra_pkg::ST_OK;
      end
    end
  end

  assign dy      = cy1_r - gy1;
  assign rowmul  = dy * CW'(GRID_W);
  assign row_end = (tx_r == cx2_r);

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      tx_r      <= cx1_r;
      ty_r      <= cy1_r;
      col_r     <= AW'(cx1_r - gx1);
      col0_r    <= AW'(cx1_r - gx1);
      rowbase_r <= AW'(rowmul);
    end else if (cmd.step) begin
      if (row_end) begin
        tx_r      <= cx1_r;
        col_r     <= col0_r;
        ty_r      <= ty_r + CW'(1);
        rowbase_r <= rowbase_r + AW'(GRID_W);
      end else begin
        tx_r  <= tx_r + CW'(1);
        col_r <= col_r + AW'(1);
      end
    end
  end

  assign run_addr = rowbase_r + col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      p_addr_r <= run_addr;
      p_el_r   <= (tx_r == tx1_r) ? xf1_r : '0;
      p_et_r   <= (ty_r == ty1_r) ? yf1_r : '0;
      p_er_r   <= (tx_r == tx2_r) ? xf2_r : TILE_SIZE;
      p_eb_r   <= (ty_r == ty2_r) ? yf2_r : TILE_SIZE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  assign idx_ext  = (IW + AW)'(idx_r);
  assign idx_addr = idx_ext[AW-1:0];
  assign idx_ok   = 32'(idx_r) < 32'(NTILES);
  assign rd_addr  = cmd.rd_tile ? idx_addr : run_addr;

  assign old_l = rd_data[EW-1:0];
  assign old_t = rd_data[2*EW-1:EW];
  assign old_r = rd_data[3*EW-1:2*EW];
  assign old_b = rd_data[4*EW-1:3*EW];

  assign new_l = (old_l < p_el_r) ? old_l : p_el_r;
  assign new_t = (old_t < p_et_r) ? old_t : p_et_r;
  assign new_r = (old_r > p_er_r) ? old_r : p_er_r;
  assign new_b = (old_b > p_eb_r) ? old_b : p_eb_r;

  assign we      = cmd.clear_wr | p_valid_r;
  assign wr_addr = cmd.clear_wr ? clr_r : p_addr_r;
  assign wr_data = cmd.clear_wr ? '0 : {new_b, new_r, new_t, new_l};

  mdra_ram #(
    .WIDTH (DW),
    .DEPTH (NTILES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .raddr   (rd_addr),
    .rdata_r (rd_data)
  );

  assign ext_l = (EW + BW)'(old_l);
  assign ext_t = (EW + BW)'(old_t);
  assign ext_r = (EW + BW)'(old_r);
  assign ext_b = (EW + BW)'(old_b);

  always_ff @(posedge clk) begin
    if (cmd.emit_add) begin
      out_status_r     <= status_r;
      out_box_left_r   <= '0;
      out_box_top_r    <= '0;
      out_box_right_r  <= '0;
      out_box_bottom_r <= '0;
    end else if (cmd.emit_rd) begin
      if (idx_ok) begin
        out_status_r     <= mdra_pkg::ST_OK;
        out_box_left_r   <= ext_l[BW-1:0];
        out_box_top_r    <= ext_t[BW-1:0];
        out_box_right_r  <= ext_r[BW-1:0];
        out_box_bottom_r <= ext_b[BW-1:0];
      end else begin
        out_status_r     <= mdra_pkg::ST_SKIP;
        out_box_left_r   <= '0;
        out_box_top_r    <= '0;
        out_box_right_r  <= '0;
        out_box_bottom_r <= '0;
      end
    end
  end

  assign out_status     = out_status_r;
  assign out_box_left   = out_box_left_r;
  assign out_box_top    = out_box_top_r;
  assign out_box_right  = out_box_right_r;
  assign out_box_bottom = out_box_bottom_r;

  assign stat.cmd_rd     = cmd_rd_r;
  assign stat.skip       = skip_r;
  assign stat.last       = row_end && (ty_r == cy2_r);
  assign stat.clear_last = (clr_r == AW'(NTILES - 1));

endmodule

### rtl/core/microtile_dirty_rect_accumulator.sv
// Add command: busy through CALC, INIT, RUN over the covered tiles and DRAIN, strobe follows; next start then.
// One tile read-modify-write per cycle through the box RAM's read and write ports.
// Ignored add and read command: busy through CALC and then INIT or RDOUT, result strobe in the cycle after.
// Results cannot be stalled; out_valid pulses one cycle per command.
// After reset the box RAM is zeroed over all GRID_W*GRID_H tiles with busy high;
// cfg_ready follows !busy, so configuration transfers wait out any command.
module microtile_dirty_rect_accumulator #(
  parameter int TILE_SHIFT = mdra_pkg::TILE_SHIFT_DEF,
  parameter int GRID_W     = mdra_pkg::GRID_W_DEF,
  parameter int GRID_H     = mdra_pkg::GRID_H_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_cmd,
  input  logic [mdra_pkg::PIX_W-1:0]        in_rect_left,
  input  logic [mdra_pkg::PIX_W-1:0]        in_rect_top,
  input  logic [mdra_pkg::PIX_END_W-1:0]    in_rect_right,
  input  logic [mdra_pkg::PIX_END_W-1:0]    in_rect_bottom,
  input  logic [mdra_pkg::TILE_IDX_W-1:0]   in_tile_index,
  output logic                              out_valid,
  output logic [mdra_pkg::STATUS_W-1:0]     out_status,
  output logic [mdra_pkg::BOX_W-1:0]        out_box_left,
  output logic [mdra_pkg::BOX_W-1:0]        out_box_top,
  output logic [mdra_pkg::BOX_W-1:0]        out_box_right,
  output logic [mdra_pkg::BOX_W-1:0]        out_box_bottom,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mdra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mdra_pkg::ORIGIN_W-1:0]     cfg_data
);

  mdra_pkg::mdra_cmd_t  cmd;
  mdra_pkg::mdra_stat_t stat;

  assign cfg_ready = !busy;

  mdra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  mdra_dp #(
    .TILE_SHIFT (TILE_SHIFT),
    .GRID_W     (GRID_W),
    .GRID_H     (GRID_H)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_cmd         (in_cmd),
    .in_rect_left   (in_rect_left),
    .in_rect_top    (in_rect_top),
    .in_rect_right  (in_rect_right),
    .in_rect_bottom (in_rect_bottom),
    .in_tile_index  (in_tile_index),
    .cfg_valid      (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_status     (out_status),
    .out_box_left   (out_box_left),
    .out_box_top    (out_box_top),
    .out_box_right  (out_box_right),
    .out_box_bottom (out_box_bottom)
  );

endmodule
